// File: hw/rtl/wlsf_pkg.sv
// Package for the wildcard line search filter.
// Holds the shared constants, register indexes, the configuration struct and
// the byte folding and pattern cleaning functions. Depends on nothing.
package wlsf_pkg;

    // Number of pattern bytes the two pattern registers hold.
    localparam int PATTERN_STORE = 16;
    // Width of the pattern length register.
    localparam int LEN_W = 5;
    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;

    // Special byte values.
    localparam logic [7:0] NEWLINE_BYTE  = 8'd10;
    localparam logic [7:0] WILDCARD_BYTE = 8'h5F;  // '_'
    localparam logic [7:0] DOT_BYTE      = 8'h2E;  // '.'
    localparam logic [7:0] UPPER_A       = 8'h41;
    localparam logic [7:0] UPPER_Z       = 8'h5A;
    localparam logic [7:0] LOWER_A       = 8'h61;
    localparam logic [7:0] LOWER_Z       = 8'h7A;
    localparam logic [7:0] DIGIT_0       = 8'h30;
    localparam logic [7:0] DIGIT_9       = 8'h39;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    // Cleaned pattern and effective length, as seen by the match logic.
    typedef struct packed {
        logic [PATTERN_STORE-1:0][7:0] pattern;
        logic [LEN_W-1:0]              length;
    } t_cfg;

    // Fold an upper case letter of the line to lower case.
    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= UPPER_A && b <= UPPER_Z) begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

    // Lowercase a pattern byte and turn anything illegal into the wildcard.
    function automatic logic [7:0] clean_byte(input logic [7:0] b);
        logic [7:0] l;
        logic [7:0] r;
        l = fold_byte(b);
        if ((l >= LOWER_A && l <= LOWER_Z) || (l >= DIGIT_0 && l <= DIGIT_9) ||
            l == DOT_BYTE || l == WILDCARD_BYTE) begin
            r = l;
        end else begin
            r = WILDCARD_BYTE;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/wlsf_cfg_regs.sv
// Configuration registers of the wildcard line search filter.
// Stores the pattern already cleaned and the saturated pattern length.
// Depends on wlsf_pkg.
module wlsf_cfg_regs
    import wlsf_pkg::*;
#(
    parameter int MATCH_W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MATCH_W);

    logic [PATTERN_STORE-1:0][7:0] r_pattern;
    logic [LEN_W-1:0]              r_length;
    logic [LEN_W-1:0]              n_length;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Saturate the requested length to what the match vector holds.
    always_comb begin
        n_length = i_cfg_data[LEN_W-1:0];
        if (n_length > MAX_LEN) begin
            n_length = MAX_LEN;
        end
    end

    // Register writes; pattern bytes are cleaned on the way in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PATTERN_STORE; k++) begin
                r_pattern[k] <= WILDCARD_BYTE;
            end
            r_length <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW: begin
                    for (int k = 0; k < 8; k++) begin
                        r_pattern[k] <= clean_byte(i_cfg_data[8*k +: 8]);
                    end
                end
                CFG_PATTERN_HIGH: begin
                    for (int k = 0; k < 8; k++) begin
                        r_pattern[k+8] <= clean_byte(i_cfg_data[8*k +: 8]);
                    end
                end
                CFG_PATTERN_LENGTH: begin
                    r_length <= n_length;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.pattern = r_pattern;
    assign o_cfg.length  = r_length;

endmodule

// File: hw/rtl/wlsf_match.sv
// Match datapath of the wildcard line search filter.
// Input byte register, shift-and partial match state and result register.
// Depends on wlsf_pkg.
module wlsf_match
    import wlsf_pkg::*;
#(
    parameter int MATCH_W = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_line_byte,
    input  t_cfg       i_cfg,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_line_matched
);

    logic               r_byte_vld;
    logic [7:0]         r_byte;
    logic [MATCH_W-1:0] r_pm;
    logic               r_hit;
    logic               r_out_vld;
    logic               r_out;

    logic [7:0]         folded;
    logic               is_nl;
    logic [MATCH_W-1:0] mask;
    logic [MATCH_W-1:0] n_pm;
    logic               tail;
    logic               n_hit;
    logic               matched;
    logic               out_free;
    logic               advance;

    // Per-position compare of the held byte against the pattern.
    always_comb begin
        folded = fold_byte(r_byte);
        is_nl  = (r_byte == NEWLINE_BYTE);
        for (int j = 0; j < MATCH_W; j++) begin
            mask[j] = (LEN_W'(j) < i_cfg.length) &&
                      (i_cfg.pattern[j] == WILDCARD_BYTE || i_cfg.pattern[j] == folded);
        end
    end

    // Shift-and update and the check of the last pattern position.
    always_comb begin
        n_pm = MATCH_W'({r_pm, 1'b1}) & mask;
        tail = 1'b0;
        for (int j = 0; j < MATCH_W; j++) begin
            if (LEN_W'(j + 1) == i_cfg.length) begin
                tail = n_pm[j];
            end
        end
        n_hit   = r_hit || tail;
        matched = (i_cfg.length == '0) || n_hit;
    end

    // A newline needs a free result slot; other bytes always move on.
    assign out_free   = !r_out_vld || i_out_ready;
    assign advance    = r_byte_vld && (!is_nl || out_free);
    assign o_in_ready = !r_byte_vld || advance;

    // Input register, match state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_vld <= 1'b0;
            r_pm       <= '0;
            r_hit      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_byte_vld <= 1'b1;
                r_byte     <= i_line_byte;
            end else if (advance) begin
                r_byte_vld <= 1'b0;
            end

            if (advance && is_nl) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            if (advance) begin
                if (is_nl) begin
                    r_pm  <= '0;
                    r_hit <= 1'b0;
                    r_out <= matched;
                end else begin
                    r_pm  <= n_pm;
                    r_hit <= n_hit;
                end
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_line_matched = r_out;

endmodule

// File: hw/rtl/wildcard_line_search_filter_top.sv
// Top level of the wildcard line search filter.
// Instantiates the configuration registers and the match datapath.
// Depends on wlsf_pkg, wlsf_cfg_regs and wlsf_match.
//
// Usage:
// Log bytes enter one per transaction on the input channel (i_in_valid,
// o_in_ready, i_line_byte). Byte 10 ends a line. For each newline one
// transaction leaves on the output channel (o_out_valid, i_out_ready,
// o_line_matched) telling whether the line held the pattern; other bytes
// give nothing. The pattern is set through the configuration channel:
// index 0 and 1 load pattern bytes 0-7 and 8-15, index 2 the length.
// Configuration writes are always accepted and must come while the block
// is idle.
// Throughput is one byte per cycle, set by the single shift-and update
// between the input register and the match state, while no newline waits
// for the result slot. A newline is accepted into the input register and
// its result then loads into the result register for the receiver. When the
// receiver stalls, the result register holds; non-newline bytes still flow,
// and a newline waits in the input register until the result slot frees.
// Reset empties the pattern (length zero matches every line), the partial
// matches and both valid flags.
module wildcard_line_search_filter_top
    import wlsf_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_line_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_line_matched
);

    localparam int MATCH_W = (PATTERN_MAX < PATTERN_STORE) ? PATTERN_MAX : PATTERN_STORE;

    t_cfg cfg;

    // Pattern and length registers.
    wlsf_cfg_regs #(
        .MATCH_W (MATCH_W)
    ) u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Byte stream matching.
    wlsf_match #(
        .MATCH_W (MATCH_W)
    ) u_match (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_line_byte    (i_line_byte),
        .i_cfg          (cfg),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_line_matched (o_line_matched)
    );

endmodule

// File: hw/rtl/wlsf_checker.sv
// Port-level checker for the wildcard line search filter.
// Bound to wildcard_line_search_filter_top; depends on wlsf_pkg.
module wlsf_checker
    import wlsf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_line_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_line_matched
);

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_line_matched))
        else $error("result changed while stalled");

    // Input back-pressure only comes from a stalled result.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output stall");

    // A fresh result follows an accepted newline transaction.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && (i_line_byte == NEWLINE_BYTE), 2))
        else $error("result without newline");

endmodule

bind wildcard_line_search_filter_top wlsf_checker u_wlsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_line_byte    (i_line_byte),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_line_matched (o_line_matched)
);

// File: dv/wildcard_line_search_filter_top_tb.sv
// Self-checking testbench for the wildcard line search filter top level.
// Streams log lines under several pattern settings and checks every line result
// against a shift-and predictor kept in a scoreboard class. Depends on wlsf_pkg.
`timescale 1ns / 100ps

module wildcard_line_search_filter_top_tb
    import wlsf_pkg::*;
;

    localparam int MAX_PATTERN  = 16;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 235;

    // Predicts the line results from the accepted bytes and checks what the block returns.
    class line_match_scoreboard #(int LEN_LIMIT = 16);
        bit [63:0]              pattern_lo;
        bit [63:0]              pattern_hi;
        bit [LEN_W-1:0]         pattern_len;
        bit [PATTERN_STORE-1:0] partial_hits;
        bit                     line_found;
        bit                     expected_matches[$];
        int                     lines_closed;
        int                     mismatches;

        function int pending();
            return expected_matches.size();
        endfunction

        function void note_config(bit [CFG_IDX_W-1:0] idx, bit [63:0] data);
            case (idx)
                CFG_PATTERN_LOW:    pattern_lo  = data;
                CFG_PATTERN_HIGH:   pattern_hi  = data;
                CFG_PATTERN_LENGTH: pattern_len = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [7:0] fold_line(bit [7:0] b);
            return (b >= UPPER_A && b <= UPPER_Z) ? (b | CASE_OFFSET) : b;
        endfunction

        // Length in use, saturated to the parameter and to the register storage.
        function int active_length();
            int n;
            n = pattern_len;
            if (n > LEN_LIMIT) n = LEN_LIMIT;
            if (n > PATTERN_STORE) n = PATTERN_STORE;
            return n;
        endfunction

        // Pattern byte j after lowercasing; anything illegal acts as the wildcard.
        function bit [7:0] pattern_char(int j);
            bit [127:0] both;
            bit [7:0]   p;
            bit         legal;
            both  = {pattern_hi, pattern_lo};
            p     = fold_line(both[j*8 +: 8]);
            legal = (p >= LOWER_A && p <= LOWER_Z) || (p >= DIGIT_0 && p <= DIGIT_9) ||
                    p == DOT_BYTE || p == WILDCARD_BYTE;
            return legal ? p : WILDCARD_BYTE;
        endfunction

        // Advance the shift-and state by one accepted line byte.
        function void note_byte(bit [7:0] b);
            bit [7:0]               c;
            bit [7:0]               p;
            bit [PATTERN_STORE-1:0] allowed;
            int                     n;
            c       = fold_line(b);
            n       = active_length();
            allowed = '0;
            for (int j = 0; j < n; j++) begin
                p          = pattern_char(j);
                allowed[j] = (p == WILDCARD_BYTE) || (p == c);
            end
            partial_hits = {partial_hits[PATTERN_STORE-2:0], 1'b1} & allowed;
            if (n > 0 && partial_hits[n-1]) line_found = 1'b1;
            if (b == NEWLINE_BYTE) begin
                expected_matches.push_back(n == 0 || line_found);
                partial_hits = '0;
                line_found   = 1'b0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(logic got);
            bit want;
            lines_closed++;
            if (expected_matches.size() == 0) begin
                report_mismatch($sformatf("line %0d: result %b with no line pending",
                                          lines_closed, got));
            end else begin
                want = expected_matches.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("line %0d: line_matched %b, expected %b",
                                              lines_closed, got, want));
                end
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [7:0]           i_line_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_line_matched;

    line_match_scoreboard #(MAX_PATTERN) sb;
    bit [7:0] log_bytes[$];
    bit       steady_traffic;
    int       cycle_count;

    wildcard_line_search_filter_top #(
        .PATTERN_MAX(MAX_PATTERN)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_line_byte   (i_line_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_line_matched(o_line_matched)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watch both channels and the configuration port on every rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_line_matched);
            if (i_cfg_valid && o_cfg_ready) sb.note_config(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_byte(i_line_byte);
        end
    end

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stalls in random bursts until the final phase.
    initial begin : result_pacing
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!steady_traffic && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // A log byte biased toward the letters and symbols that patterns use.
    function automatic bit [7:0] text_byte();
        int       pick;
        bit [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            b = LOWER_A + 8'($urandom_range(0, 5));
            if ($urandom_range(0, 1)) b = b - CASE_OFFSET;
        end else if (pick < 70) begin
            b = DIGIT_0 + 8'($urandom_range(0, 9));
        end else if (pick < 75) begin
            b = $urandom_range(0, 1) ? DOT_BYTE : WILDCARD_BYTE;
        end else begin
            do b = 8'($urandom_range(0, 255)); while (b == NEWLINE_BYTE);
        end
        return b;
    endfunction

    function automatic bit [63:0] pattern_word();
        bit [63:0] w;
        for (int k = 0; k < 8; k++) begin
            w[k*8 +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : text_byte();
        end
        return w;
    endfunction

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) log_bytes.push_back(s[k]);
    endtask

    // Append bytes that satisfy the first count pattern positions, with random case.
    task automatic add_pattern_copy(input int count);
        bit [7:0] p;
        for (int j = 0; j < count; j++) begin
            p = sb.pattern_char(j);
            if (p == WILDCARD_BYTE) begin
                p = text_byte();
            end else if (p >= LOWER_A && p <= LOWER_Z && $urandom_range(0, 1)) begin
                p = p - CASE_OFFSET;
            end
            log_bytes.push_back(p);
        end
    endtask

    // Mostly lines that hold the pattern, plus truncated copies, near misses, plain lines and noise.
    task automatic build_lines(input int count);
        int n;
        int kind;
        n = sb.active_length();
        log_bytes.delete();
        while (log_bytes.size() < count) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 6)) log_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(0, 5)) log_bytes.push_back(text_byte());
                if (kind == 1) begin
                    add_pattern_copy($urandom_range(0, n));
                end else if (kind < 8) begin
                    add_pattern_copy(n);
                    if (kind == 2 && n > 0) begin
                        void'(log_bytes.pop_back());
                        log_bytes.push_back(text_byte());
                    end
                end
                repeat ($urandom_range(0, 5)) log_bytes.push_back(text_byte());
                log_bytes.push_back(NEWLINE_BYTE);
            end
        end
        // Sometimes leave a line open across the next register update.
        if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 4)) log_bytes.push_back(text_byte());
        end
    endtask

    // Send the queued bytes, one transaction each, with random gaps until the final phase.
    task automatic send_log();
        foreach (log_bytes[k]) begin
            @(negedge i_clk);
            if (!steady_traffic && $urandom_range(0, 4) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_line_byte <= log_bytes[k];
            do @(posedge i_clk); while (!o_in_ready);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        log_bytes.delete();
    endtask

    task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_pattern(input bit [63:0] lo, input bit [63:0] hi,
                                input bit [LEN_W-1:0] len);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LENGTH, {{(64-LEN_W){1'b0}}, len});
    endtask

    // Wait until every expected line result has come back and the pipeline is empty.
    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        sb             = new();
        steady_traffic = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_PATTERN_LOW;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_line_byte    = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset pattern has length zero, so every line matches, even an empty one.
        add_text("\n");
        log_bytes.push_back(8'h00);
        log_bytes.push_back(8'hFF);
        add_text("\n");
        send_log();
        drain();

        // Upper case pattern letter and a zero byte acting as the wildcard.
        load_pattern(64'h0000_0000_6400_6241, 64'h0, 5'd4);
        add_text("xaBZd\nabd\n");
        send_log();
        drain();

        // Trailing wildcard completes on the newline; the open line carries over.
        load_pattern(64'h0000_0000_0000_FF63, 64'h0, 5'd2);
        add_text("ac\nc");
        send_log();
        drain();

        // Length above the storage saturates to sixteen.
        load_pattern({8{DOT_BYTE}}, '1, 5'd31);
        add_text("....\n");
        send_log();
        drain();

        // Random phases over a range of settings; the last one runs without stalls.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_pattern(pattern_word(), pattern_word(), 5'($urandom_range(1, 16)));
                1: load_pattern('0, '0, 5'd16);
                2: load_pattern('1, '1, 5'd31);
                3: load_pattern(pattern_word(), pattern_word(), 5'd0);
                4: load_pattern(pattern_word(), pattern_word(), 5'd1);
                5: load_pattern(pattern_word(), pattern_word(), 5'd16);
                6: load_pattern(pattern_word(), pattern_word(), 5'($urandom_range(17, 31)));
                default: begin
                    steady_traffic = 1'b1;
                    load_pattern(pattern_word(), pattern_word(), 5'($urandom_range(1, 16)));
                end
            endcase
            build_lines(PHASE_BYTES);
            send_log();
            drain();
        end

        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/wlsf_pkg.sv
hw/rtl/wlsf_cfg_regs.sv
hw/rtl/wlsf_match.sv
hw/rtl/wildcard_line_search_filter_top.sv
hw/rtl/wlsf_checker.sv
dv/wildcard_line_search_filter_top_tb.sv
